[rtl/bfha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bfha_pkg;

  // table geometry and fixed field widths
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int SIZE_W          = 16;
  localparam int TAG_W           = 8;
  localparam int SLACK_W         = 17;
  localparam int SLOT_W          = 4;

  // tag that marks a free hole
  localparam logic [TAG_W-1:0]   HOLE_TAG    = 8'd72;
  localparam logic [SLACK_W-1:0] SLACK_RESET = 17'd100;

  // item kinds
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_ALLOC  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FAIL = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // search token passed from cell to cell (slot index travels beside it)
  typedef struct packed {
    logic               valid;
    logic               found;
    logic               exact;
    logic [SLACK_W-1:0] best_left;
  } scan_t;

  // broadcast write into the cell row (index travels beside it)
  typedef struct packed {
    logic              we;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } wr_t;

endpackage

`default_nettype wire

[rtl/bfha_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfha_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [CW-1:0]              count,
  input  wire logic [bfha_pkg::SIZE_W-1:0] req,
  input  wire bfha_pkg::wr_t              wr,
  input  wire logic [IW-1:0]              wr_idx,
  input  wire bfha_pkg::scan_t            tok_in,
  input  wire logic [IW-1:0]              slot_in,
  output bfha_pkg::scan_t                 tok_out,
  output logic [IW-1:0]                   slot_out
);
  import bfha_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX);

  logic [SIZE_W-1:0] size_r;
  logic [TAG_W-1:0]  tag_r;
  scan_t             tok_r, tok_nxt;
  logic [IW-1:0]     slot_r, slot_nxt;
  logic              qualifies;
  logic [SIZE_W-1:0] left;

  // entry storage, written by append or by a granted allocation
  always_ff @(posedge clk) begin
    if (wr.we && (wr_idx == MY_IDX)) begin
      size_r <= wr.size;
      tag_r  <= wr.tag;
    end
  end

  // compare this entry against the passing token
  always_comb begin
    qualifies = tok_in.valid && !tok_in.exact && (MY_POS < count) &&
                (tag_r == HOLE_TAG) && (size_r >= req);
    left      = size_r - req;
    tok_nxt   = tok_in;
    slot_nxt  = slot_in;
    if (qualifies) begin
      if (left == '0) begin
        tok_nxt.exact = 1'b1;
        tok_nxt.found = 1'b1;
        slot_nxt      = MY_IDX;
      end else if ({1'b0, left} < tok_in.best_left) begin
        tok_nxt.best_left = {1'b0, left};
        tok_nxt.found     = 1'b1;
        slot_nxt          = MY_IDX;
      end
    end
  end

  // token register toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.found     <= tok_nxt.found;
    tok_r.exact     <= tok_nxt.exact;
    tok_r.best_left <= tok_nxt.best_left;
    slot_r          <= slot_nxt;
  end

  assign tok_out  = tok_r;
  assign slot_out = slot_r;

endmodule

`default_nettype wire

[rtl/best_fit_hole_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake               payload
// in_       input      in_valid / in_ready     in_kind, in_block_size, in_owner_tag
// out_      output     out_valid / out_ready   out_status, out_slot
// cfg_      input      cfg_we (no wait)        cfg_wdata (slack limit)
//
// an append item's result is registered, then goes to the output register once free
// an allocate item walks the cell row one cell a cycle
// one item is in work at a time; a new item is taken while the last result
// still sits in the output register
// rst_n is synchronous: clears the entry count, slack limit and all control
// table entries are not cleared; only entries below the count are ever looked at

module best_fit_hole_allocator #(
  parameter int MAX_ENTRIES = bfha_pkg::DEF_MAX_ENTRIES
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_kind,
  input  wire logic [bfha_pkg::SIZE_W-1:0]  in_block_size,
  input  wire logic [bfha_pkg::TAG_W-1:0]   in_owner_tag,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic [bfha_pkg::SLOT_W-1:0]       out_slot,
  input  wire logic                         cfg_we,
  input  wire logic [bfha_pkg::SLACK_W-1:0] cfg_wdata
);
  import bfha_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CW > IW) ? CW : IW;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r;
  logic [SLACK_W-1:0]  slack_r;
  logic [SIZE_W-1:0]   req_r;
  logic [TAG_W-1:0]    tag_r;
  scan_t               launch_r;
  status_t             res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;

  logic                in_acc;
  logic                load_out;
  logic                is_full;
  logic                scan_end;
  wr_t                 wr;
  logic [IW-1:0]       wr_idx;
  logic [IW+SLOT_W-1:0] best_ext;
  logic [CW+SLOT_W-1:0] count_ext;

  scan_t               tok_in  [MAX_ENTRIES];
  scan_t               tok_out [MAX_ENTRIES];
  logic [IW-1:0]       slot_in [MAX_ENTRIES];
  logic [IW-1:0]       slot_out[MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] tok_valid_vec;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_kind == KIND_ALLOC) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  in_ready = 1'b0;
      S_DONE:  load_out = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_acc    = in_valid && in_ready;
  assign is_full   = (count_r == FULL_COUNT);
  assign scan_end  = (state_r == S_SCAN) && tok_out[MAX_ENTRIES-1].valid;
  assign best_ext  = {{SLOT_W{1'b0}}, slot_out[MAX_ENTRIES-1]};
  assign count_ext = {{SLOT_W{1'b0}}, count_r};

  // write into the cell row: append at the tail, or grant at scan end
  always_comb begin
    wr.we   = 1'b0;
    wr.size = req_r;
    wr.tag  = tag_r;
    wr_idx  = slot_out[MAX_ENTRIES-1];
    if (in_acc && (in_kind == KIND_APPEND)) begin
      wr.we   = !is_full;
      wr.size = in_block_size;
      wr.tag  = in_owner_tag;
      wr_idx  = count_r[IW-1:0];
    end else if (scan_end) begin
      wr.we   = tok_out[MAX_ENTRIES-1].found;
    end
  end

  // control registers and launch token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      count_r        <= '0;
      slack_r        <= SLACK_RESET;
      launch_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      launch_r.valid <= in_acc && (in_kind == KIND_ALLOC);
      if (cfg_we) begin
        slack_r <= cfg_wdata;
      end
      if (in_acc && (in_kind == KIND_APPEND) && !is_full) begin
        count_r <= count_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    launch_r.found     <= 1'b0;
    launch_r.exact     <= 1'b0;
    launch_r.best_left <= slack_r;
  end

  // item payload and result registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_block_size;
      tag_r <= in_owner_tag;
    end
    if (in_acc && (in_kind == KIND_APPEND)) begin
      res_status_r <= is_full ? ST_FULL : ST_DONE;
      res_slot_r   <= is_full ? '0 : count_ext[SLOT_W-1:0];
    end else if (scan_end) begin
      res_status_r <= tok_out[MAX_ENTRIES-1].found ? ST_DONE : ST_FAIL;
      res_slot_r   <= tok_out[MAX_ENTRIES-1].found ? best_ext[SLOT_W-1:0] : '0;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

  // row of cells, token handed one cell per cycle
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i]  = launch_r;
      assign slot_in[i] = '0;
    end else begin : g_link
      assign tok_in[i]  = tok_out[i-1];
      assign slot_in[i] = slot_out[i-1];
    end
    assign tok_valid_vec[i] = tok_out[i].valid;

    bfha_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .count    (count_r),
      .req      (req_r),
      .wr       (wr),
      .wr_idx   (wr_idx),
      .tok_in   (tok_in[i]),
      .slot_in  (slot_in[i]),
      .tok_out  (tok_out[i]),
      .slot_out (slot_out[i])
    );
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  // at most one search token in the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({launch_r.valid, tok_valid_vec}))
    else $error("more than one search token in flight");

  // entry count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count beyond table size");

  // a granted slot lies inside the filled part of the table
  a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (scan_end && tok_out[MAX_ENTRIES-1].found) |->
      (CMP_W'(slot_out[MAX_ENTRIES-1]) < CMP_W'(count_r)))
    else $error("granted slot outside table");

  // a stored append bumps the count by one
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_kind == KIND_APPEND) && !is_full) |=>
      (count_r == $past(count_r) + 1'b1))
    else $error("append did not advance entry count");

  // tokens only travel while a scan is under way
  a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
    (|tok_valid_vec) |-> (state_r == S_SCAN))
    else $error("search token outside scan");

endmodule

`default_nettype wire

[test/best_fit_hole_allocator_tb.sv]
`timescale 1ns / 1ps

module best_fit_hole_allocator_tb;
  import bfha_pkg::*;

  localparam int TBL_DEPTH  = DEF_MAX_ENTRIES;
  localparam int SETTLE     = DEF_MAX_ENTRIES + 8;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES  = 11;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } outcome_t;

  // dut ports
  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_kind;
  logic [SIZE_W-1:0]  in_block_size;
  logic [TAG_W-1:0]   in_owner_tag;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic               cfg_we;
  logic [SLACK_W-1:0] cfg_wdata;

  // mirror of the block table and register
  logic [SIZE_W-1:0]  tbl_size [TBL_DEPTH];
  logic [TAG_W-1:0]   tbl_tag  [TBL_DEPTH];
  int                 tbl_count;
  logic [SLACK_W-1:0] tbl_slack;

  outcome_t outcome_q[$];
  int       err_count;
  int       burst_left;
  int       idle_cycles;
  logic [7:0] ready_mask;
  int       ready_left;
  int       ready_pos;

  best_fit_hole_allocator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_block_size (in_block_size),
    .in_owner_tag  (in_owner_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // append or best fit on the mirrored table, queue the outcome of one accepted item
  task automatic best_fit_outcome(input logic kind, input logic [SIZE_W-1:0] req,
                                  input logic [TAG_W-1:0] tag);
    outcome_t           res;
    logic               found;
    int                 best_slot;
    logic [SLACK_W-1:0] best_left;
    logic [SLACK_W-1:0] left;
    res.status = ST_DONE;
    res.slot   = '0;
    if (kind == KIND_APPEND) begin
      if (tbl_count >= TBL_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        tbl_size[tbl_count] = req;
        tbl_tag[tbl_count]  = tag;
        res.slot = tbl_count[SLOT_W-1:0];
        tbl_count++;
      end
    end else begin
      found     = 1'b0;
      best_slot = 0;
      best_left = tbl_slack;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_tag[i] != HOLE_TAG) continue;
        if (tbl_size[i] < req) continue;
        left = {1'b0, tbl_size[i]} - {1'b0, req};
        if (left == '0) begin
          found     = 1'b1;
          best_slot = i;
          break;
        end
        if (left < best_left) begin
          best_left = left;
          best_slot = i;
          found     = 1'b1;
        end
      end
      if (!found) begin
        res.status = ST_FAIL;
      end else begin
        tbl_size[best_slot] = req;
        tbl_tag[best_slot]  = tag;
        res.slot = best_slot[SLOT_W-1:0];
      end
    end
    outcome_q.push_back(res);
  endtask

  // send one item; valid stays high on return so a following item can chain
  task automatic send_item(input logic kind, input logic [SIZE_W-1:0] sz,
                           input logic [TAG_W-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if ($urandom_range(3) != 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_block_size <= sz;
    in_owner_tag  <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    best_fit_outcome(kind, sz, tag);
  endtask

  // drop valid and let every outstanding result drain
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write, only called with the block idle
  task automatic write_slack(input logic [SLACK_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tbl_slack = value;
    cfg_we    <= 1'b0;
  endtask

  // allocation on an empty table always fails
  task automatic test_empty_table();
    send_item(KIND_ALLOC, 16'd0, HOLE_TAG);
    send_item(KIND_ALLOC, 16'hFFFF, 8'hFF);
  endtask

  // fill every slot, then one append past the end
  task automatic test_fill_table();
    logic [SIZE_W-1:0] sizes [TBL_DEPTH];
    logic [TAG_W-1:0]  tags  [TBL_DEPTH];
    sizes = '{16'd100, 16'd0, 16'hFFFF, 16'd500, 16'd150, 16'd150, 16'd1000, 16'hFFFF,
              16'd32768, 16'd1, 16'd200, 16'd40000, 16'd120, 16'd99, 16'd7, 16'd60000};
    tags  = '{HOLE_TAG, HOLE_TAG, HOLE_TAG, 8'h41, HOLE_TAG, HOLE_TAG, HOLE_TAG, 8'h00,
              HOLE_TAG, HOLE_TAG, 8'hFF, HOLE_TAG, HOLE_TAG, HOLE_TAG, HOLE_TAG, HOLE_TAG};
    write_slack(SLACK_RESET);
    for (int i = 0; i < TBL_DEPTH; i++) send_item(KIND_APPEND, sizes[i], tags[i]);
    send_item(KIND_APPEND, 16'h1234, HOLE_TAG);
  endtask

  // exact fit, zero size, ties and slack extremes
  task automatic test_fit_rules();
    write_slack('0);
    send_item(KIND_ALLOC, 16'd0, 8'h42);
    send_item(KIND_ALLOC, 16'd140, HOLE_TAG);
    send_item(KIND_ALLOC, 16'd1000, HOLE_TAG);
    write_slack(SLACK_RESET);
    send_item(KIND_ALLOC, 16'd140, 8'h55);
    send_item(KIND_ALLOC, 16'd0, HOLE_TAG);
    write_slack(17'd65536);
    send_item(KIND_ALLOC, 16'd1, HOLE_TAG);
    send_item(KIND_ALLOC, 16'hFFFF, HOLE_TAG);
    send_item(KIND_APPEND, 16'hFFFF, 8'hFF);
  endtask

  // random phases, each under its own slack limit
  task automatic test_random_phases();
    int                holes [TBL_DEPTH];
    int                n_holes;
    int                pick;
    int                h;
    int                r;
    int                off;
    logic [SIZE_W-1:0] sz;
    logic [TAG_W-1:0]  tag;
    logic [SLACK_W-1:0] slack_pick;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: slack_pick = '0;
        1: slack_pick = 17'd65536;
        2: slack_pick = 17'd1;
        3: slack_pick = 17'd65535;
        4: slack_pick = SLACK_RESET;
        default: slack_pick = SLACK_W'(($urandom_range(1) != 0) ? $urandom_range(0, 300)
                                                                : $urandom_range(0, 65536));
      endcase
      write_slack(slack_pick);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        n_holes = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_tag[i] == HOLE_TAG) begin
            holes[n_holes] = i;
            n_holes++;
          end
        end
        pick = $urandom_range(99);
        if (pick < 8) begin
          send_item(KIND_APPEND, SIZE_W'($urandom_range(0, 65535)),
                    TAG_W'($urandom_range(0, 255)));
        end else if (pick < 16 || n_holes == 0) begin
          // noise: fully random request, tag only spent when holes are plenty
          tag = (n_holes > 6) ? TAG_W'($urandom_range(0, 255)) : HOLE_TAG;
          send_item(KIND_ALLOC, SIZE_W'($urandom_range(0, 65535)), tag);
        end else begin
          // aim at one hole: exact, a bit smaller, much smaller or too big
          h = holes[$urandom_range(n_holes - 1)];
          r = $urandom_range(19);
          if (r < 10) begin
            off = 0;
          end else if (r < 16) begin
            off = $urandom_range(0, (tbl_size[h] < 150) ? tbl_size[h] : 150);
          end else if (r < 17) begin
            off = $urandom_range(0, tbl_size[h]);
          end else begin
            off = -$urandom_range(1, 50);
          end
          if (tbl_size[h] - off > 65535) sz = 16'hFFFF;
          else sz = SIZE_W'(tbl_size[h] - off);
          if (off < 0 || ((n_holes > 6) && ($urandom_range(3) == 0)))
            tag = TAG_W'($urandom_range(0, 255));
          else
            tag = HOLE_TAG;
          send_item(KIND_ALLOC, sz, tag);
        end
      end
    end
  endtask

  // result check and watchdog
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected item, status", out_status, -1);
        end else begin
          want = outcome_q.pop_front();
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_slot !== want.slot) report_mismatch("slot", out_slot, want.slot);
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver stall pattern, bit 0 of each mask keeps stalls short
  always @(posedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(3))
        0: ready_mask = 8'hFF;
        1: ready_mask = 8'h01;
        default: ready_mask = 8'($urandom_range(0, 255)) | 8'h01;
      endcase
      ready_left = $urandom_range(16, 64);
      ready_pos  = 0;
    end
    ready_left--;
    out_ready <= ready_mask[ready_pos % 8];
    ready_pos++;
  end

  initial begin
    err_count   = 0;
    burst_left  = 0;
    idle_cycles = 0;
    ready_left  = 0;
    ready_pos   = 0;
    ready_mask  = 8'hFF;
    tbl_count   = 0;
    tbl_slack   = SLACK_RESET;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl_size[i] = '0;
      tbl_tag[i]  = '0;
    end
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_APPEND;
    in_block_size <= '0;
    in_owner_tag  <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_fit_rules();
    test_random_phases();

    drain_results();
    if (outcome_q.size() != 0) report_mismatch("items left over", outcome_q.size(), 0);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
